// File: design/scu_pkg.sv
// ============================================================================
// scu_pkg
// Shared types and constants of the sine/cosine unit: Q30 datapath word,
// reduction constants and polynomial coefficients.
// ============================================================================
`default_nettype none

package scu_pkg;

    // Q30 datapath word; the reduced angle spans a little over +-pi/2
    localparam int ACC_W  = 34;
    localparam int Q_FRAC = 30;

    typedef logic signed [ACC_W-1:0] t_acc;

    // data that rides along with each beat through the polynomial cells
    typedef struct packed {
        t_acc f;     // reduced angle, Q30
        t_acc g;     // f*f, Q30
        logic flip;  // negate the final value
    } t_side;

    // 1/pi in Q32
    localparam logic [31:0] INVPI_Q32 = 32'd1367130551;
    // pi split: C1 = 201/64 exactly, C2 in Q50
    localparam logic [7:0]  C1_NUM    = 8'd201;
    localparam logic [39:0] C2_Q50    = 40'd1089481086604;
    localparam logic [19:0] C2_HI     = C2_Q50[39:20];
    localparam logic [19:0] C2_LO     = C2_Q50[19:0];

    // minimax coefficients, Q30
    localparam t_acc POLY_R1 = -34'sd178956863;
    localparam t_acc POLY_R2 =  34'sd8947518;
    localparam t_acc POLY_R3 = -34'sd212681;
    localparam t_acc POLY_R4 =  34'sd2794;
    localparam t_acc ONE_Q30 =  34'sd1073741824;
    localparam t_acc ZERO    =  34'sd0;

endpackage

`default_nettype wire

// File: design/scu_in_if.sv
// ============================================================================
// scu_in_if
// Request channel: function select and angle.
// ============================================================================
`default_nettype none

interface scu_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [31:0] angle;

    modport source (output valid, output op, output angle, input ready);
    modport sink   (input valid, input op, input angle, output ready);
endinterface

`default_nettype wire

// File: design/scu_out_if.sv
// ============================================================================
// scu_out_if
// Result channel: sine or cosine value.
// ============================================================================
`default_nettype none

interface scu_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// File: design/scu_reduce.sv
// ============================================================================
// scu_reduce
// Range reduction pipeline: |x|, n = round(|x|/pi + op/2), xn = n - op/2,
// f = |x| - xn*(C1+C2), rounded to Q30. Seven stages, one beat per cycle while i_en is high.
// ============================================================================
`default_nettype none

module scu_reduce #(
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_valid,
    input  wire                 i_op,
    input  wire  signed [31:0]  i_angle,
    output logic                o_valid,
    output scu_pkg::t_acc       o_f,
    output logic                o_flip
);
    import scu_pkg::*;

    localparam int SH = ANGLE_FRAC_BITS + 32;
    localparam int NW = 64 - SH;        // width of n
    localparam int MW = NW + 1;         // width of m = 2*xn
    localparam int PW = MW + 20;        // m times a half of C2
    localparam int CW = MW + 8;         // m times C1_NUM
    localparam int XS = 40 - ANGLE_FRAC_BITS;

    // stage 1
    logic          r1_v, r1_cos, r1_neg;
    logic [31:0]   r1_mag;
    // stage 2
    logic          r2_v, r2_cos, r2_neg;
    logic [63:0]   r2_prod;
    logic [31:0]   r2_mag;
    // stage 3
    logic          r3_v, r3_flip;
    logic [MW-1:0] r3_m;
    logic [31:0]   r3_mag;
    // stage 4
    logic          r4_v, r4_flip;
    logic [63:0]   r4_x40, r4_t1;
    logic [PW-1:0] r4_pl, r4_ph;
    // stage 5
    logic          r5_v, r5_flip;
    logic [63:0]   r5_dx, r5_t2;
    // stage 6
    logic          r6_v, r6_flip;
    logic [63:0]   r6_d;
    // stage 7
    logic          r7_v, r7_flip;
    t_acc          r7_f;

    logic [31:0]        n_mag;
    logic [63:0]        n_sum, n_bias;
    logic [NW-1:0]      n_n;
    logic [MW-1:0]      n_m;
    logic [63:0]        n_t1, n_t2;
    logic signed [64:0] n_rnd, n_fsh;

    always_comb begin
        n_mag  = i_angle[31] ? (32'd0 - $unsigned(i_angle)) : $unsigned(i_angle);

        n_bias = r2_cos ? (64'd1 << SH) : (64'd1 << (SH - 1));
        n_sum  = r2_prod + n_bias;
        n_n    = n_sum[63:SH];
        n_m    = {n_n, 1'b0} - MW'(r2_cos);

        n_t1   = 64'(CW'(r3_m) * CW'(C1_NUM)) << 33;
        n_t2   = ((64'(r4_ph) << 20) + 64'(r4_pl) + 64'd1024) >> 11;

        // half away from zero: a negative value takes one less
        n_rnd  = $signed({r6_d[63], r6_d}) + (r6_d[63] ? 65'sd511 : 65'sd512);
        n_fsh  = n_rnd >>> 10;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mag  <= n_mag;
            r1_cos  <= i_op;
            r1_neg  <= i_angle[31];

            r2_prod <= 64'(r1_mag) * 64'(INVPI_Q32);
            r2_mag  <= r1_mag;
            r2_cos  <= r1_cos;
            r2_neg  <= r1_neg;

            r3_m    <= n_m;
            r3_mag  <= r2_mag;
            r3_flip <= n_n[0] ^ (!r2_cos && r2_neg);

            r4_x40  <= 64'(r3_mag) << XS;
            r4_t1   <= n_t1;
            r4_pl   <= PW'(r3_m) * PW'(C2_LO);
            r4_ph   <= PW'(r3_m) * PW'(C2_HI);
            r4_flip <= r3_flip;

            r5_dx   <= r4_x40 - r4_t1;
            r5_t2   <= n_t2;
            r5_flip <= r4_flip;

            r6_d    <= r5_dx - r5_t2;
            r6_flip <= r5_flip;

            r7_f    <= n_fsh[ACC_W-1:0];
            r7_flip <= r6_flip;
        end
    end

    assign o_valid = r7_v;
    assign o_f     = r7_f;
    assign o_flip  = r7_flip;

endmodule

`default_nettype wire

// File: design/scu_mac_cell.sv
// ============================================================================
// scu_mac_cell
// One link of the polynomial chain: acc = round_q30(a*b) + c, two stages.
// Carries the side data of its beat along to the next cell.
// ============================================================================
`default_nettype none

module scu_mac_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_valid,
    input  scu_pkg::t_acc       i_a,
    input  scu_pkg::t_acc       i_b,
    input  scu_pkg::t_acc       i_c,
    input  scu_pkg::t_side      i_side,
    output logic                o_valid,
    output scu_pkg::t_acc       o_acc,
    output scu_pkg::t_side      o_side
);
    import scu_pkg::*;

    localparam int PW = 2 * ACC_W;

    logic                 r_pv, r_av;
    logic signed [PW-1:0] r_prod;
    t_acc                 r_c, r_acc;
    t_side                r_pside, r_aside;

    logic signed [PW-1:0] n_rnd, n_sh;

    always_comb begin
        // half away from zero: a negative product takes one less
        n_rnd = r_prod + (r_prod[PW-1] ? PW'((64'd1 << (Q_FRAC - 1)) - 64'd1)
                                       : PW'(64'd1 << (Q_FRAC - 1)));
        n_sh  = n_rnd >>> Q_FRAC;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_av <= 1'b0;
        end else if (i_en) begin
            r_pv <= i_valid;
            r_av <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= i_a * i_b;
            r_c     <= i_c;
            r_pside <= i_side;
            r_acc   <= n_sh[ACC_W-1:0] + r_c;
            r_aside <= r_pside;
        end
    end

    assign o_valid = r_av;
    assign o_acc   = r_acc;
    assign o_side  = r_aside;

endmodule

`default_nettype wire

// File: design/scu_post.sv
// ============================================================================
// scu_post
// Sign fix, clamp to +-1.0, rounding to the output format, and the output
// register with a one-beat skid slot.
// ============================================================================
`default_nettype none

module scu_post #(
    parameter int RESULT_FRAC_BITS = 30
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  scu_pkg::t_acc       i_acc,
    input  wire                 i_flip,
    input  wire                 i_ready,
    output logic                o_valid,
    output logic signed [31:0]  o_value,
    output logic                o_en
);
    import scu_pkg::*;

    localparam int RS = Q_FRAC - RESULT_FRAC_BITS;
    localparam logic [ACC_W:0] HALF = ((ACC_W + 1)'(1) << RS) >> 1;

    logic               r_v1;
    t_acc               r_res;
    logic               r_out_valid, r_skid_valid;
    logic signed [31:0] r_out, r_skid;

    t_acc               n_neg, n_clip;
    logic               n_adj;
    logic [ACC_W:0]     n_sum;
    logic signed [ACC_W:0] n_sh;
    logic signed [31:0] n_value;
    logic               en;

    assign en = !r_skid_valid;

    always_comb begin
        n_neg  = i_flip ? -i_acc : i_acc;
        if (n_neg > ONE_Q30) begin
            n_clip = ONE_Q30;
        end else if (n_neg < -ONE_Q30) begin
            n_clip = -ONE_Q30;
        end else begin
            n_clip = n_neg;
        end

        n_adj   = (RS != 0) && r_res[ACC_W-1];
        n_sum   = {r_res[ACC_W-1], r_res} + HALF - (ACC_W + 1)'(n_adj);
        n_sh    = $signed(n_sum) >>> RS;
        n_value = n_sh[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1         <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            if (r_out_valid && !i_ready) begin
                r_skid_valid <= r_v1;
            end else begin
                r_out_valid  <= r_v1;
            end
        end else if (i_ready) begin
            // skid slot is full, so the output register holds a beat too
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= n_clip;
            if (r_out_valid && !i_ready) begin
                r_skid <= n_value;
            end else begin
                r_out  <= n_value;
            end
        end else if (i_ready) begin
            r_out <= r_skid;
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_out;
    assign o_en    = en;

endmodule

`default_nettype wire

// File: design/sine_cosine_unit.sv
// ============================================================================
// sine_cosine_unit
// Fixed-point sine/cosine: range reduction by pi, then a degree-9 odd
// minimax polynomial evaluated by a chain of six multiply-add cells.
// ============================================================================
//
//  Port    Dir  Fields        Format
//  i_in    in   op, angle     op: 0 sine, 1 cosine; angle signed, radians
//  o_out   out  value         signed, RESULT_FRAC_BITS fraction bits
//
//  One beat accepted per cycle while i_in.ready is high; from acceptance to
//  o_out.valid a beat passes 7 reduction stages, 6 cells of 2 stages, 1 sign/clamp
//  stage and 1 output register. Reset clears only the valid bits.
//  When o_out stalls, one more beat lands in the skid slot; i_in.ready
//  drops in the following cycle and the whole chain holds until the slot
//  drains.
// ============================================================================
`default_nettype none

module sine_cosine_unit #(
    parameter int ANGLE_FRAC_BITS  = 16,
    parameter int RESULT_FRAC_BITS = 30
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    scu_in_if.sink      i_in,
    scu_out_if.source   o_out
);
    import scu_pkg::*;

    localparam int NCELL = 6;

    logic  en;
    logic  red_v, red_flip;
    t_acc  red_f;

    logic  c_vin  [NCELL];
    logic  c_vout [NCELL];
    t_acc  c_a    [NCELL];
    t_acc  c_b    [NCELL];
    t_acc  c_c    [NCELL];
    t_acc  c_acc  [NCELL];
    t_side c_sin  [NCELL];
    t_side c_sout [NCELL];

    assign i_in.ready = en;

    scu_reduce #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_op    (i_in.op),
        .i_angle (i_in.angle),
        .o_valid (red_v),
        .o_f     (red_f),
        .o_flip  (red_flip)
    );

    // cell 0: g = f*f
    assign c_vin[0] = red_v;
    assign c_a[0]   = red_f;
    assign c_b[0]   = red_f;
    assign c_c[0]   = ZERO;
    assign c_sin[0] = '{f: red_f, g: ZERO, flip: red_flip};

    // cell 1: R4*g + R3; g joins the side data here
    assign c_vin[1] = c_vout[0];
    assign c_a[1]   = POLY_R4;
    assign c_b[1]   = c_acc[0];
    assign c_c[1]   = POLY_R3;
    assign c_sin[1] = '{f: c_sout[0].f, g: c_acc[0], flip: c_sout[0].flip};

    // cells 2..4: Horner steps on g
    assign c_vin[2] = c_vout[1];
    assign c_a[2]   = c_acc[1];
    assign c_b[2]   = c_sout[1].g;
    assign c_c[2]   = POLY_R2;
    assign c_sin[2] = c_sout[1];

    assign c_vin[3] = c_vout[2];
    assign c_a[3]   = c_acc[2];
    assign c_b[3]   = c_sout[2].g;
    assign c_c[3]   = POLY_R1;
    assign c_sin[3] = c_sout[2];

    assign c_vin[4] = c_vout[3];
    assign c_a[4]   = c_acc[3];
    assign c_b[4]   = c_sout[3].g;
    assign c_c[4]   = ZERO;
    assign c_sin[4] = c_sout[3];

    // cell 5: f + f*(g*R(g))
    assign c_vin[5] = c_vout[4];
    assign c_a[5]   = c_sout[4].f;
    assign c_b[5]   = c_acc[4];
    assign c_c[5]   = c_sout[4].f;
    assign c_sin[5] = c_sout[4];

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        scu_mac_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (c_vin[k]),
            .i_a     (c_a[k]),
            .i_b     (c_b[k]),
            .i_c     (c_c[k]),
            .i_side  (c_sin[k]),
            .o_valid (c_vout[k]),
            .o_acc   (c_acc[k]),
            .o_side  (c_sout[k])
        );
    end

    scu_post #(
        .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
    ) u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c_vout[NCELL-1]),
        .i_acc   (c_acc[NCELL-1]),
        .i_flip  (c_sout[NCELL-1].flip),
        .i_ready (o_out.ready),
        .o_valid (o_out.valid),
        .o_value (o_out.value),
        .o_en    (en)
    );

endmodule

`default_nettype wire
